// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: assertion macros shared by the RTL
// Implication and next-cycle checks; they are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OHI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define OHI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define OHI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OHI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ohi_pkg.sv =====
// ----------------------------------------------------------------------------
// ohi_pkg: shared types and constants
// Word formats, command and status groups and codes of the hash insert block.
// ----------------------------------------------------------------------------
`default_nettype none
package ohi_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int KEY_BITS    = 16;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = 7;
	localparam int DIVS_W      = 8;
	localparam int TOTAL_W     = 12;
	localparam int PROBE_W     = 6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PROBE_MODE   = 2'd0;
	localparam logic [1:0] CFG_TABLE_SIZE   = 2'd1;
	localparam logic [1:0] CFG_STEP_BASE    = 2'd2;
	localparam logic [1:0] CFG_STEP_MODULUS = 2'd3;

	// Probe modes; the unused code behaves as linear.
	localparam logic [1:0] MODE_LINEAR    = 2'd0;
	localparam logic [1:0] MODE_QUADRATIC = 2'd1;
	localparam logic [1:0] MODE_DOUBLE    = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_PLACED  = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_ZERO    = 2'd2;
	localparam logic [1:0] STAT_CLEARED = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [KEY_BITS-1:0] key;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  slot_index;
		logic [5:0]  probe_count;
		logic [1:0]  status;
		logic [11:0] total_probes;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV_HOME,
		S_DIV_SMOD,
		S_DIV_STRIDE,
		S_PROBE
	} state_t;

	typedef enum logic [1:0] {
		DIV_HOME,
		DIV_SMOD,
		DIV_STRIDE
	} div_sel_t;

	typedef struct packed {
		logic       load;
		logic       clear;
		logic       div_start;
		div_sel_t   div_sel;
		logic       store_home;
		logic       store_stride;
		logic       probe_init;
		logic       probe_step;
		logic       place;
		logic       emit;
		logic [1:0] emit_code;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_zero;
		logic div_done;
		logic slot_free;
		logic last_probe;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/open_addressing_hash_insert.sv =====
// A clear or a zero key is settled in the decode state, from which its result word is registered.
// An insert runs three 16-step remainder passes on one shared divider, then
// probes one slot a cycle until one is free or the effective table size is tried.
// One request at a time; busy is high from acceptance until the result strobe.
// Reset empties the table, clears the probe total and loads default registers.
// ----------------------------------------------------------------------------
// open_addressing_hash_insert: hash table insert block
// Places keys with linear, quadratic or double-hashing probing, or clears.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module open_addressing_hash_insert
	import ohi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire in_item_t   item,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	output out_item_t       result,
	output logic            done
);

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Sequencer.
	ohi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath.
	ohi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result),
		.done      (done)
	);

	// Checks.
	`OHI_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`OHI_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`OHI_ASSERT_IMP(a_unplaced_zero, clk, arst_n, done && result.status != STAT_PLACED, result.slot_index == '0 && result.probe_count == '0)
	`OHI_ASSERT_IMP(a_clear_total, clk, arst_n, done && result.status == STAT_CLEARED, result.total_probes == '0)

endmodule
`default_nettype wire

// ===== rtl/ohi_divider.sv =====
// ----------------------------------------------------------------------------
// ohi_divider: iterative remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none
module ohi_divider
	import ohi_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [KEY_BITS-1:0] dividend,
	input  wire logic [DIVS_W-1:0]   divisor,
	output logic                     done,
	output logic [DIVS_W-1:0]        rem
);

	localparam int CNT_W = $clog2(KEY_BITS);

	logic                active_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [KEY_BITS-1:0] num_q;
	logic [DIVS_W-1:0]   div_q;
	logic [DIVS_W-1:0]   rem_q;
	logic [DIVS_W:0]     trial;

	// Shift in the next dividend bit and subtract when it fits.
	assign trial = {rem_q, num_q[KEY_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(KEY_BITS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (active_q) begin
			num_q <= {num_q[KEY_BITS-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= DIVS_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[DIVS_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/ohi_datapath.sv =====
// ----------------------------------------------------------------------------
// ohi_datapath: registers, slot occupancy and probe arithmetic
// Holds configuration, the request word, the occupancy bits and the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ohi_datapath
	import ohi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire in_item_t   item,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_wdata,
	input  wire ctrl_cmd_t  cmd,
	output dp_status_t      stat,
	output out_item_t       result,
	output logic            done
);

	logic [1:0]          mode_q;
	logic [6:0]          tsize_q;
	logic [7:0]          sbase_q;
	logic [7:0]          smod_q;

	logic                req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IDX_W-1:0]    home_q;
	logic [IDX_W-1:0]    strmod_q;
	logic [IDX_W-1:0]    slot_q;
	logic [IDX_W-1:0]    qinc_q;
	logic [IDX_W-1:0]    i_q;
	logic [TABLE_DEPTH-1:0] occ_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                done_q;
	out_item_t           res_q;

	logic [SIZE_W-1:0]   eff;
	logic                div_start;
	logic [KEY_BITS-1:0] div_num;
	logic [DIVS_W-1:0]   div_den;
	logic                div_done;
	logic [DIVS_W-1:0]   div_rem;
	logic [DIVS_W-1:0]   stride;
	logic [IDX_W-1:0]    inc;
	logic [IDX_W:0]      slot_sum;
	logic [IDX_W-1:0]    slot_nxt;
	logic [IDX_W:0]      q_sum;
	logic [IDX_W-1:0]    q_nxt;
	logic [TOTAL_W-1:0]  total_nxt;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_LINEAR;
			tsize_q <= 7'd50;
			sbase_q <= 8'd30;
			smod_q  <= 8'd25;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROBE_MODE:   mode_q  <= cfg_wdata[1:0];
				CFG_TABLE_SIZE:   tsize_q <= cfg_wdata[6:0];
				CFG_STEP_BASE:    sbase_q <= cfg_wdata;
				CFG_STEP_MODULUS: smod_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Effective table size: zero counts as one, saturated at the depth.
	always_comb begin
		if (tsize_q == '0) begin
			eff = SIZE_W'(1);
		end else if (tsize_q > SIZE_W'(TABLE_DEPTH)) begin
			eff = SIZE_W'(TABLE_DEPTH);
		end else begin
			eff = tsize_q;
		end
	end

	// The second hash stride, clamped to at least one.
	always_comb begin
		if (sbase_q <= div_rem) begin
			stride = DIVS_W'(1);
		end else begin
			stride = sbase_q - div_rem;
		end
	end

	// Operand selection for the shared remainder unit.
	always_comb begin
		div_start = cmd.div_start;
		case (cmd.div_sel)
			DIV_HOME: begin
				div_num = key_q;
				div_den = DIVS_W'(eff);
			end
			DIV_SMOD: begin
				div_num = key_q;
				div_den = (smod_q == '0) ? DIVS_W'(1) : smod_q;
			end
			DIV_STRIDE: begin
				div_num = KEY_BITS'(stride);
				div_den = DIVS_W'(eff);
			end
			default: begin
				div_num = key_q;
				div_den = DIVS_W'(eff);
			end
		endcase
	end

	ohi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Next slot: every step adds an offset below the size, so one wrap suffices.
	always_comb begin
		case (mode_q)
			MODE_QUADRATIC: inc = qinc_q;
			MODE_DOUBLE:    inc = strmod_q;
			default:        inc = (eff == SIZE_W'(1)) ? '0 : IDX_W'(1);
		endcase
		slot_sum = {1'b0, slot_q} + {1'b0, inc};
		if (slot_sum >= (IDX_W+1)'(eff)) begin
			slot_nxt = IDX_W'(slot_sum - (IDX_W+1)'(eff));
		end else begin
			slot_nxt = slot_sum[IDX_W-1:0];
		end
		// The quadratic offset grows by two each step, kept reduced.
		q_sum = {1'b0, qinc_q} + (IDX_W+1)'(2);
		if (eff == SIZE_W'(1)) begin
			q_nxt = '0;
		end else if (q_sum >= (IDX_W+1)'(eff)) begin
			q_nxt = IDX_W'(q_sum - (IDX_W+1)'(eff));
		end else begin
			q_nxt = q_sum[IDX_W-1:0];
		end
		total_nxt = total_q + TOTAL_W'(i_q);
	end

	// Control state of the table: occupancy, running total and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.emit | cmd.place;
			if (cmd.clear) begin
				occ_q   <= '0;
				total_q <= '0;
			end else if (cmd.place) begin
				occ_q[slot_q] <= 1'b1;
				total_q       <= total_nxt;
			end
		end
	end

	// Request word, hash values and probe registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= item.req_type;
			key_q <= item.key;
		end
		if (cmd.store_home && div_done) begin
			home_q <= div_rem[IDX_W-1:0];
		end
		if (cmd.store_stride && div_done) begin
			strmod_q <= div_rem[IDX_W-1:0];
		end
		if (cmd.probe_init) begin
			slot_q <= home_q;
			i_q    <= '0;
			qinc_q <= (eff == SIZE_W'(1)) ? '0 : IDX_W'(1);
		end else if (cmd.probe_step) begin
			slot_q <= slot_nxt;
			i_q    <= i_q + 1'b1;
			qinc_q <= q_nxt;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			res_q.slot_index   <= 6'(slot_q);
			res_q.probe_count  <= 6'(i_q);
			res_q.status       <= STAT_PLACED;
			res_q.total_probes <= total_nxt;
		end else if (cmd.emit) begin
			res_q.slot_index   <= '0;
			res_q.probe_count  <= '0;
			res_q.status       <= cmd.emit_code;
			res_q.total_probes <= cmd.clear ? '0 : total_q;
		end
	end

	always_comb begin
		stat.is_clear   = (req_q == REQ_CLEAR);
		stat.is_zero    = (key_q == '0);
		stat.div_done   = div_done;
		stat.slot_free  = ~occ_q[slot_q];
		stat.last_probe = ((IDX_W+1)'(i_q) == (IDX_W+1)'(eff - SIZE_W'(1)));
	end

	assign result = res_q;
	assign done   = done_q;

endmodule
`default_nettype wire

// ===== rtl/ohi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ohi_ctrl: request sequencer
// Steps each insert through hashing, probing and the result word; clears and zero keys go straight to their result.
// ----------------------------------------------------------------------------
`default_nettype none
module ohi_ctrl
	import ohi_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire dp_status_t stat,
	output ctrl_cmd_t       cmd,
	output logic            busy
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.div_sel = DIV_HOME;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_clear) begin
					cmd.clear     = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_code = STAT_CLEARED;
					state_nxt     = S_IDLE;
				end else if (stat.is_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = STAT_ZERO;
					state_nxt     = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_HOME;
					state_nxt     = S_DIV_HOME;
				end
			end
			S_DIV_HOME: begin
				cmd.store_home = 1'b1;
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_SMOD;
					state_nxt     = S_DIV_SMOD;
				end
			end
			S_DIV_SMOD: begin
				// The stride is formed from the remainder as it completes.
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_STRIDE;
					state_nxt     = S_DIV_STRIDE;
				end
			end
			S_DIV_STRIDE: begin
				cmd.store_stride = 1'b1;
				if (stat.div_done) begin
					cmd.probe_init = 1'b1;
					state_nxt      = S_PROBE;
				end
			end
			S_PROBE: begin
				if (stat.slot_free) begin
					cmd.place = 1'b1;
					state_nxt = S_IDLE;
				end else if (stat.last_probe) begin
					cmd.emit      = 1'b1;
					cmd.emit_code = STAT_FULL;
					state_nxt     = S_IDLE;
				end else begin
					cmd.probe_step = 1'b1;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== sim/tb_open_addressing_hash_insert.sv =====
// ----------------------------------------------------------------------------
// tb_open_addressing_hash_insert: self-checking bench for the hash insert block
// Drives directed and random bursts of insert and clear words under several register settings,
// predicts every result word from a local model of the slot table and compares
// each field as the done strobe marks it.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_open_addressing_hash_insert
	import ohi_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 900000;

	// Shadow of the slot table that predicts each result word.
	class hash_scoreboard;
		logic [KEY_BITS-1:0] keys [TABLE_DEPTH];
		logic [11:0]         total;
		logic [1:0]          mode;
		logic [6:0]          tsize;
		logic [7:0]          sbase;
		logic [7:0]          smod;
		out_item_t           pending [$];
		int                  errors;

		function void reset_state();
			foreach (keys[i]) keys[i] = '0;
			total = '0;
			mode = MODE_LINEAR;
			tsize = 7'd50;
			sbase = 8'd30;
			smod = 8'd25;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_PROBE_MODE: mode = val[1:0];
				CFG_TABLE_SIZE: tsize = val[6:0];
				CFG_STEP_BASE: sbase = val;
				default: smod = val;
			endcase
		endfunction

		// Works out the result of one accepted request word.
		function void note_request(in_item_t w);
			out_item_t r;
			int s, home, m, stride, sl;
			r = '0;
			if (w.req_type == REQ_CLEAR) begin
				foreach (keys[i]) keys[i] = '0;
				total = '0;
				r.status = STAT_CLEARED;
			end else if (w.key == '0) begin
				r.status = STAT_ZERO;
			end else begin
				s = (tsize == 0) ? 1 : ((tsize > TABLE_DEPTH) ? TABLE_DEPTH : int'(tsize));
				home = int'(w.key) % s;
				m = (smod == 0) ? 1 : int'(smod);
				stride = int'(sbase) - int'(w.key) % m;
				if (stride < 1) stride = 1;
				r.status = STAT_FULL;
				for (int i = 0; i < s; i++) begin
					if (mode == MODE_QUADRATIC) sl = (home + i * i) % s;
					else if (mode == MODE_DOUBLE) sl = (home + i * stride) % s;
					else sl = (home + i) % s;
					if (keys[sl] == '0) begin
						keys[sl] = w.key;
						total = total + 12'(i);
						r.slot_index = 6'(sl);
						r.probe_count = 6'(i);
						r.status = STAT_PLACED;
						break;
					end
				end
			end
			r.total_probes = total;
			pending.push_back(r);
		endfunction

		// Compares one result word with the oldest prediction.
		function void check_result(out_item_t got);
			out_item_t exp_r;
			if (pending.size() == 0) begin
				report("result word with nothing predicted");
				return;
			end
			exp_r = pending.pop_front();
			if (got.slot_index !== exp_r.slot_index)
				report($sformatf("slot_index %0d, predicted %0d", got.slot_index,
					exp_r.slot_index));
			if (got.probe_count !== exp_r.probe_count)
				report($sformatf("probe_count %0d, predicted %0d", got.probe_count,
					exp_r.probe_count));
			if (got.status !== exp_r.status)
				report($sformatf("status %0d, predicted %0d", got.status, exp_r.status));
			if (got.total_probes !== exp_r.total_probes)
				report($sformatf("total_probes %0d, predicted %0d", got.total_probes,
					exp_r.total_probes));
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_item_t    item = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;
	out_item_t   result;
	logic        done;
	int          cycles = 0;
	hash_scoreboard sb;

	open_addressing_hash_insert dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.result(result), .done(done)
	);

	always #4 clk = ~clk;

	// Result monitor and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done === 1'b1) sb.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("open_addressing_hash_insert verification failed");
			$finish;
		end
	end

	// Writes one register while the block is idle.
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// Offers one word and holds it until the block takes it; the block is
	// busy in the cycle after acceptance, so the extra wait before the next word costs nothing.
	task automatic send_word(logic req, logic [KEY_BITS-1:0] k);
		in_item_t w;
		w.req_type = req;
		w.key = k;
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_request(w);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_all(logic [1:0] m, logic [7:0] ts, logic [7:0] b, logic [7:0] md);
		drain();
		write_reg(CFG_PROBE_MODE, m);
		write_reg(CFG_TABLE_SIZE, ts);
		write_reg(CFG_STEP_BASE, b);
		write_reg(CFG_STEP_MODULUS, md);
	endtask

	// Random key: small keys crowd home slots, full range covers every bit.
	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return 16'($urandom_range(1, 200));
			3: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	// Bursts of random length with random gaps; a clear now and then.
	task automatic random_phase(int n);
		int left;
		left = n;
		while (left > 0) begin
			repeat ($urandom_range(1, 12)) begin
				if (left > 0) begin
					if ($urandom_range(0, 40) == 0) send_word(REQ_CLEAR, 16'($urandom));
					else send_word(REQ_INSERT, pick_key());
					left--;
				end
			end
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: defaults, extremes, zero key, full table, clear.
		send_word(REQ_INSERT, 16'd0);
		send_word(REQ_INSERT, 16'd50);
		send_word(REQ_INSERT, 16'd100);
		send_word(REQ_INSERT, 16'hFFFF);
		send_word(REQ_INSERT, 16'd100);
		send_word(REQ_CLEAR, 16'hFFFF);
		set_all(MODE_LINEAR, 8'd0, 8'd1, 8'd0);
		send_word(REQ_INSERT, 16'd7);
		send_word(REQ_INSERT, 16'd9);
		set_all(MODE_QUADRATIC, 8'd4, 8'd255, 8'd255);
		repeat (5) send_word(REQ_INSERT, 16'd8);
		send_word(REQ_CLEAR, 16'd0);
		set_all(MODE_DOUBLE, 8'd127, 8'd1, 8'd255);
		repeat (4) send_word(REQ_INSERT, 16'd640);
		set_all(2'd3, 8'd65, 8'd255, 8'd1);
		repeat (3) send_word(REQ_INSERT, 16'd64);
		send_word(REQ_CLEAR, 16'd1);

		// Random phases across settings, the table refilling between clears.
		for (int ph = 0; ph < 16; ph++) begin
			set_all(2'($urandom_range(0, 3)),
				(ph % 4 == 0) ? 8'd64 : 8'($urandom_range(0, 127)),
				(ph % 5 == 0) ? 8'd255 : 8'($urandom),
				(ph % 6 == 0) ? 8'd0 : 8'($urandom));
			if (ph == 8) drain();
			if ($urandom_range(0, 1)) send_word(REQ_CLEAR, 16'($urandom));
			random_phase(100);
		end

		drain();
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("open_addressing_hash_insert verification clean");
		else
			$display("open_addressing_hash_insert verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/ohi_pkg.sv
rtl/ohi_divider.sv
rtl/ohi_datapath.sv
rtl/ohi_ctrl.sv
rtl/open_addressing_hash_insert.sv
sim/tb_open_addressing_hash_insert.sv
